@@ rtl/ames_pkg.sv @@
// Package for the adjacency matrix edge store.
// Holds the word types, operation and status codes and matrix sizes.
// No dependencies.
`default_nettype none

package ames_pkg;

  // Matrix geometry and field widths
  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = 6;
  localparam int VCNT_W       = 7;
  localparam int COUNT_W      = 13;

  // Configuration register indexes
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_DIRECTED     = 1'b1;

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [VTX_W-1:0]        vtx_t;

  // Input word
  typedef struct packed {
    logic [1:0] op;
    vtx_t       from_vertex;
    vtx_t       to_vertex;
  } edge_op_t;

  // Result word
  typedef struct packed {
    logic [1:0]         status;
    logic               connected;
    logic [COUNT_W-1:0] edge_total;
  } edge_result_t;

  // Row write request towards the row store
  typedef struct packed {
    logic en;
    vtx_t addr;
    row_t row;
  } row_wr_t;

endpackage

`default_nettype wire

@@ rtl/ames_row_mem.sv @@
// Row store of the edge matrix: one row of bits per source vertex.
// Depends on ames_pkg. Rows carry valid bits so a clear needs no sweep,
// and a row written in the same cycle as it is read is forwarded.
`default_nettype none

module ames_row_mem (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     rd_en,
  input  wire ames_pkg::vtx_t     rd_addr,
  input  wire ames_pkg::row_wr_t  wr,
  input  wire                     clear_all,
  output ames_pkg::row_t          rd_row
);
  import ames_pkg::*;

  row_t                   mem [MAX_VERTICES];
  row_t                   rd_q;
  vtx_t                   rd_addr_q;
  logic                   fwd;
  row_t                   fwd_row;
  logic [MAX_VERTICES-1:0] row_valid;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.row;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      fwd_row   <= wr.row;
    end
  end

  // Forward flag: the row read was being written at the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr.en && (wr.addr == rd_addr);
    end
  end

  // Row valid bits; a row that is not valid reads as all zero.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  assign rd_row = fwd ? fwd_row : (row_valid[rd_addr_q] ? rd_q : '0);

endmodule

`default_nettype wire

@@ rtl/adjacency_matrix_edge_store.sv @@
// Adjacency matrix edge store: each accepted word passes the stage register and
// the output register to its result word, held longer while the result side stalls.
// Throughput is one word per cycle while the result side does not stall, set by
// the single read and write port of the row store. A synchronous reset clears
// every edge and the counter and sets 64 vertices, undirected; it needs no sweep.
`default_nettype none

module adjacency_matrix_edge_store (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire ames_pkg::edge_op_t in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output ames_pkg::edge_result_t  out_data,
  input  wire                     cfg_write,
  input  wire                     cfg_index,
  input  wire [6:0]               cfg_data
);
  import ames_pkg::*;

  logic [VCNT_W-1:0]  vertex_count;
  logic               directed_mode;
  logic [COUNT_W-1:0] edge_counter;
  logic [COUNT_W-1:0] edge_counter_next;

  logic               s1_valid;
  logic [1:0]         s1_op;
  vtx_t               s1_from;
  vtx_t               s1_to;
  vtx_t               s1_row;
  vtx_t               s1_col;

  logic               advance;
  logic               accept;
  logic               commit;
  vtx_t               rd_addr;
  vtx_t               col_sel;
  row_t               cur_row;
  row_t               new_row;
  row_wr_t            wr;
  logic               clear_all;
  logic               bit_now;
  logic [VCNT_W-1:0]  n_eff;
  logic [13:0]        n_sq;
  logic               in_range;
  edge_result_t       result;

  // Handshake: the stage register moves on whenever the output register frees.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;
  assign commit   = s1_valid && advance;

  // In undirected mode only the bit with row not above column is kept.
  always_comb begin
    if (directed_mode || (in_data.from_vertex < in_data.to_vertex)) begin
      rd_addr = in_data.from_vertex;
      col_sel = in_data.to_vertex;
    end else begin
      rd_addr = in_data.to_vertex;
      col_sel = in_data.from_vertex;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VCNT_W'(MAX_VERTICES);
      directed_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vertex_count  <= cfg_data;
        REG_DIRECTED:     directed_mode <= cfg_data[0];
        default:          vertex_count  <= vertex_count;
      endcase
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= in_data.op;
      s1_from <= in_data.from_vertex;
      s1_to   <= in_data.to_vertex;
      s1_row  <= rd_addr;
      s1_col  <= col_sel;
    end
  end

  // Effective vertex count, full limit and range check
  assign n_eff    = (vertex_count > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                            : vertex_count;
  assign n_sq     = {7'd0, n_eff} * {7'd0, n_eff};
  assign in_range = ({1'b0, s1_from} < n_eff) && ({1'b0, s1_to} < n_eff);
  assign bit_now  = cur_row[s1_col];

  // Operation decode and result
  always_comb begin
    new_row           = cur_row;
    wr.en             = 1'b0;
    wr.addr           = s1_row;
    edge_counter_next = edge_counter;
    clear_all         = 1'b0;
    result.status     = ST_OK;
    result.connected  = 1'b0;
    case (s1_op)
      OP_ADD: begin
        if ({1'b0, edge_counter} == n_sq) begin
          result.status = ST_FULL;
        end else if (!in_range) begin
          result.status = ST_RANGE;
        end else begin
          new_row[s1_col]   = 1'b1;
          wr.en             = 1'b1;
          edge_counter_next = edge_counter + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (edge_counter == '0) begin
          result.status = ST_EMPTY;
        end else if (!in_range) begin
          result.status = ST_RANGE;
        end else if (bit_now) begin
          new_row[s1_col]   = 1'b0;
          wr.en             = 1'b1;
          edge_counter_next = edge_counter - 1'b1;
        end
      end
      OP_QUERY: begin
        if (!in_range) begin
          result.status = ST_RANGE;
        end else begin
          result.connected = bit_now;
        end
      end
      default: begin
        clear_all         = 1'b1;
        edge_counter_next = '0;
      end
    endcase
    wr.row            = new_row;
    wr.en             = wr.en && commit;
    clear_all         = (clear_all && commit) || cfg_write;
    result.edge_total = edge_counter_next;
  end

  // Edge counter
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      edge_counter <= '0;
    end else if (commit) begin
      edge_counter <= edge_counter_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= result;
    end
  end

  ames_row_mem u_row_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .clear_all (clear_all),
    .rd_row    (cur_row)
  );

endmodule

`default_nettype wire

@@ rtl/ames_checker.sv @@
// Port-level checks for the adjacency matrix edge store, bound to the top.
// Depends on ames_pkg and adjacency_matrix_edge_store.
`default_nettype none

module ames_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire ames_pkg::edge_result_t  out_data
);
  import ames_pkg::*;

  // Reset empties the output side.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // Only a successful query reports a connection.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.connected |-> out_data.status == ST_OK)
    else $error("connection reported with a failing status");

  // A remove refused as empty leaves the counter at zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_EMPTY |-> out_data.edge_total == '0)
    else $error("empty status with a nonzero edge total");

  // The counter never passes the full matrix.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.edge_total <= COUNT_W'(MAX_VERTICES * MAX_VERTICES))
    else $error("edge total beyond the matrix size");

endmodule

bind adjacency_matrix_edge_store ames_checker u_ames_checker (.*);

`default_nettype wire
